// File: src/conv3x3_mirror_offset_clamp_top_defines.svh
// assertion macros shared by the filter modules
`ifndef CONV3X3_MIRROR_OFFSET_CLAMP_TOP_DEFINES_SVH
`define CONV3X3_MIRROR_OFFSET_CLAMP_TOP_DEFINES_SVH

// condition holds at every edge out of reset
`define CMOC_CHECK(label, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond)) \
		else $error(msg);

// consequent holds in the same cycle
`define CMOC_IMPL(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// consequent holds in the next cycle
`define CMOC_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: src/cmoc_pkg.sv
// types, constants and helpers of the 3x3 convolution filter
package cmoc_pkg;

	localparam int KERNEL_SIZE   = 3;
	localparam int TAPS          = KERNEL_SIZE * KERNEL_SIZE;
	localparam int SLOTS         = 3;
	localparam int SLOT_W        = 2;
	localparam int BANKS         = 4;
	localparam int BANK_W        = 2;
	localparam int PIX_W         = 8;
	localparam int COEF_W        = 16;
	localparam int ACC_W         = 28;
	localparam int ROW_W         = 16;
	localparam int RAW_WIDTH_W   = 11;
	localparam int KROW_W        = 48;
	localparam int CFG_INDEX_W   = 3;
	localparam int MAX_WIDTH_DEF = 1024;
	localparam int FIFO_DEPTH    = 16;
	localparam int MIN_DIM       = 2;
	localparam int WIDTH_RESET   = 512;
	localparam int HEIGHT_RESET  = 512;
	localparam int ROUND_OFFSET  = 128 * 256;
	localparam int PIX_MAX       = 255;

	localparam logic [KROW_W-1:0] KTOP_RESET = 48'h0000_0000_FF00;
	localparam logic [KROW_W-1:0] KMID_RESET = 48'h0000_0000_0000;
	localparam logic [KROW_W-1:0] KBOT_RESET = 48'h0100_0000_0000;

	typedef enum logic {
		OP_PIXEL = 1'b0,
		OP_FLUSH = 1'b1
	} op_e;

	typedef enum logic [CFG_INDEX_W-1:0] {
		REG_WIDTH  = 3'd0,
		REG_HEIGHT = 3'd1,
		REG_KTOP   = 3'd2,
		REG_KMID   = 3'd3,
		REG_KBOT   = 3'd4
	} cfg_reg_e;

	typedef struct packed {
		op_e              op;
		logic [PIX_W-1:0] pixel_in;
	} feed_t;

	typedef struct packed {
		logic [PIX_W-1:0] pixel_out;
		logic             frame_last;
	} result_t;

	typedef struct packed {
		logic en;
		logic [COEF_W-1:0] coef;
	} coef_load_t;

	// word moving down the multiply-accumulate chain
	typedef struct packed {
		logic                         valid;
		logic                         last;
		logic [TAPS-1:0][PIX_W-1:0]   pix;
		logic signed [ACC_W-1:0]      acc;
	} cell_bus_t;

	function automatic cfg_reg_e row_reg(input int ky);
		cfg_reg_e r;
		case (ky)
			0: r = REG_KTOP;
			1: r = REG_KMID;
			default: r = REG_KBOT;
		endcase
		return r;
	endfunction

	function automatic logic [COEF_W-1:0] coef_reset(input int k);
		logic [KROW_W-1:0] row;
		case (k / KERNEL_SIZE)
			0: row = KTOP_RESET;
			1: row = KMID_RESET;
			default: row = KBOT_RESET;
		endcase
		return row[COEF_W*(k % KERNEL_SIZE) +: COEF_W];
	endfunction

endpackage

// File: src/conv3x3_mirror_offset_clamp_top.sv
// top level of the streaming 3x3 convolution filter
// Streaming 3x3 convolution with top and left edges mirrored, bottom and right edges repeated,
// +128 offset and 0..255 clamp. The block takes one word per clock on the feed channel and
// returns at most one result word for it, in raster order, once its window is complete, through
// the ram read stage, the chain of nine multiply-accumulate cells and the clamp stage. Rows live
// in three rotating row buffers, each split into four column banks so that the three columns of
// a window are read together. feed_stall rises only when 16 results are outstanding (queued or
// still in the chain), so with result_stall low the block runs at one word per clock.
// Configuration writes are taken at any time and cfg_ready stays high; write only while idle.
// The row buffers are not cleared after reset: there is no clearing pass.
`include "conv3x3_mirror_offset_clamp_top_defines.svh"
module conv3x3_mirror_offset_clamp_top #(
	parameter int MAX_WIDTH = cmoc_pkg::MAX_WIDTH_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               feed_valid,
	output logic                               feed_stall,
	input  cmoc_pkg::feed_t                    feed,
	output logic                               result_valid,
	input  logic                               result_stall,
	output cmoc_pkg::result_t                  result,
	input  logic                               cfg_valid,
	output logic                               cfg_ready,
	input  logic [cmoc_pkg::CFG_INDEX_W-1:0]   cfg_index,
	input  logic [cmoc_pkg::KROW_W-1:0]        cfg_data
);
	import cmoc_pkg::*;

	localparam int COLW       = $clog2(MAX_WIDTH);
	localparam int WW         = $clog2(MAX_WIDTH + 1);
	localparam int CMPW       = (WW > RAW_WIDTH_W) ? WW : RAW_WIDTH_W;
	localparam int BANK_DEPTH = (MAX_WIDTH + BANKS - 1) / BANKS;
	localparam int BAW        = (BANK_DEPTH > 1) ? $clog2(BANK_DEPTH) : 1;
	localparam int W_RESET    = (WIDTH_RESET > MAX_WIDTH) ? MAX_WIDTH : WIDTH_RESET;

	// configuration
	logic [WW-1:0]     w_q;
	logic [ROW_W-1:0]  h_q;
	logic              cfg_wr;
	logic [CMPW-1:0]   raw_w;
	logic [WW-1:0]     w_new;
	logic [ROW_W-1:0]  h_new;

	// stream positions
	logic [COLW-1:0]   in_col_q, out_col_q;
	logic [ROW_W-1:0]  in_row_q, out_row_q;
	logic [SLOT_W-1:0] in_slot_q, out_slot_q;
	logic              ahead_q;

	logic              take, is_pix, emit, ready;
	logic [WW-1:0]     in_col_p1, out_col_p1, need_col;
	logic [ROW_W:0]    in_row_p1, out_row_p1;
	logic              in_col_end, in_row_end, out_col_end, out_row_end;
	logic [COLW-1:0]   in_col_n;
	logic [ROW_W-1:0]  in_row_n, need_row;
	logic              wrap, ahead_mid, frame_end;

	// window fetch
	logic [COLW-1:0]   col_l, col_m, col_r;
	logic [WW-1:0]     cl_raw;
	logic [SLOT_W-1:0] sl_top, sl_bot;
	logic [BAW-1:0]    bank_raddr [BANKS];
	logic [BAW-1:0]    wr_addr;
	logic [PIX_W-1:0]  rd_data [SLOTS][BANKS];

	logic              v_s1;
	logic              last_s1;
	logic [SLOT_W-1:0] slot_s1 [KERNEL_SIZE];
	logic [BANK_W-1:0] colb_s1 [KERNEL_SIZE];

	cell_bus_t         chain [TAPS+1];
	coef_load_t        loads [TAPS];

	logic signed [ACC_W-1:0] sum;
	logic [PIX_W-1:0]  pix_clamped;
	logic              fin_v_s11;
	result_t           fin_s11;
	logic              credit_full;

	function automatic logic [COLW-1:0] col_fix(input logic [WW-1:0] x, input logic [WW-1:0] w);
		logic [WW-1:0] r;
		r = (x >= w) ? w - WW'(1) : x;
		return COLW'(r);
	endfunction

	function automatic logic [SLOT_W-1:0] slot_inc(input logic [SLOT_W-1:0] s,
			input logic [SLOT_W-1:0] k);
		logic [SLOT_W:0] t;
		t = {1'b0, s} + {1'b0, k};
		if (t >= (SLOT_W+1)'(SLOTS)) begin
			t = t - (SLOT_W+1)'(SLOTS);
		end
		return t[SLOT_W-1:0];
	endfunction

	// ---------------- configuration ----------------
	assign cfg_ready = 1'b1;
	assign cfg_wr    = cfg_valid & cfg_ready;
	assign raw_w     = CMPW'(cfg_data[RAW_WIDTH_W-1:0]);
	assign w_new     = (raw_w < CMPW'(MIN_DIM)) ? WW'(MIN_DIM) :
			(raw_w > CMPW'(MAX_WIDTH)) ? WW'(MAX_WIDTH) : WW'(raw_w);
	assign h_new     = (cfg_data[ROW_W-1:0] < ROW_W'(MIN_DIM)) ? ROW_W'(MIN_DIM) :
			cfg_data[ROW_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			w_q <= WW'(W_RESET);
			h_q <= ROW_W'(HEIGHT_RESET);
		end else if (cfg_wr) begin
			case (cfg_index)
				REG_WIDTH: begin
					w_q <= w_new;
				end
				REG_HEIGHT: begin
					h_q <= h_new;
				end
				default: begin
				end
			endcase
		end
	end

	// ---------------- position control ----------------
	assign take   = feed_valid & ~feed_stall;
	assign is_pix = take & (feed.op == OP_PIXEL);

	assign in_col_p1  = WW'(in_col_q) + WW'(1);
	assign in_col_end = (in_col_p1 >= w_q);
	assign in_row_p1  = {1'b0, in_row_q} + (ROW_W+1)'(1);
	assign in_row_end = (in_row_p1 >= {1'b0, h_q});

	assign in_col_n = !is_pix ? in_col_q : in_col_end ? '0 : COLW'(in_col_p1);
	assign in_row_n = (!is_pix || !in_col_end) ? in_row_q :
			in_row_end ? '0 : in_row_p1[ROW_W-1:0];
	assign wrap      = is_pix & in_col_end & in_row_end;
	assign ahead_mid = ahead_q | wrap;

	assign out_col_p1  = WW'(out_col_q) + WW'(1);
	assign out_col_end = (out_col_p1 >= w_q);
	assign out_row_p1  = {1'b0, out_row_q} + (ROW_W+1)'(1);
	assign out_row_end = (out_row_p1 >= {1'b0, h_q});
	assign frame_end   = out_col_end & out_row_end;

	// the last pixel the next result needs, rows and columns clamped at the far edge
	assign need_row = out_row_end ? h_q - ROW_W'(1) : out_row_p1[ROW_W-1:0];
	assign need_col = out_col_end ? w_q - WW'(1) : out_col_p1;
	assign ready    = ahead_mid || (in_row_n > need_row) ||
			(in_row_n == need_row && WW'(in_col_n) > need_col);
	assign emit     = take & ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_col_q   <= '0;
			in_row_q   <= '0;
			in_slot_q  <= '0;
			out_col_q  <= '0;
			out_row_q  <= '0;
			out_slot_q <= '0;
			ahead_q    <= 1'b0;
		end else begin
			in_col_q <= in_col_n;
			in_row_q <= in_row_n;
			if (is_pix && in_col_end) begin
				in_slot_q <= slot_inc(in_slot_q, SLOT_W'(1));
			end
			if (emit) begin
				if (out_col_end) begin
					out_col_q  <= '0;
					out_slot_q <= slot_inc(out_slot_q, SLOT_W'(1));
					out_row_q  <= out_row_end ? '0 : out_row_p1[ROW_W-1:0];
				end else begin
					out_col_q <= COLW'(out_col_p1);
				end
			end
			ahead_q <= ahead_mid & ~(emit & frame_end);
		end
	end

	// ---------------- window fetch ----------------
	// column -1 mirrors to column 1, column width to the last column
	assign cl_raw = (out_col_q == '0) ? WW'(1) : WW'(out_col_q) - WW'(1);
	assign col_l  = col_fix(cl_raw, w_q);
	assign col_m  = col_fix(WW'(out_col_q), w_q);
	assign col_r  = col_fix(out_col_p1, w_q);

	// row -1 mirrors to row 1, row height to the last row
	assign sl_top = (out_row_q == '0) ? slot_inc(out_slot_q, SLOT_W'(1)) :
			slot_inc(out_slot_q, SLOT_W'(2));
	assign sl_bot = out_row_end ? out_slot_q : slot_inc(out_slot_q, SLOT_W'(1));

	// distinct window columns always differ in their low bits, so each bank serves one column
	always_comb begin
		for (int b = 0; b < BANKS; b++) begin
			if (col_r[BANK_W-1:0] == BANK_W'(b)) begin
				bank_raddr[b] = BAW'(col_r >> BANK_W);
			end else if (col_m[BANK_W-1:0] == BANK_W'(b)) begin
				bank_raddr[b] = BAW'(col_m >> BANK_W);
			end else begin
				bank_raddr[b] = BAW'(col_l >> BANK_W);
			end
		end
	end

	assign wr_addr = BAW'(in_col_q >> BANK_W);

	for (genvar s = 0; s < SLOTS; s++) begin : g_slot
		for (genvar b = 0; b < BANKS; b++) begin : g_bank
			cmoc_ram #(
				.WIDTH(PIX_W),
				.DEPTH(BANK_DEPTH)
			) u_ram (
				.clk   (clk),
				.we    (is_pix && in_slot_q == SLOT_W'(s) &&
						in_col_q[BANK_W-1:0] == BANK_W'(b)),
				.waddr (wr_addr),
				.wdata (feed.pixel_in),
				.raddr (bank_raddr[b]),
				.rdata (rd_data[s][b])
			);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else begin
			v_s1 <= emit;
		end
	end

	always_ff @(posedge clk) begin
		last_s1    <= frame_end;
		slot_s1[0] <= sl_top;
		slot_s1[1] <= out_slot_q;
		slot_s1[2] <= sl_bot;
		colb_s1[0] <= col_l[BANK_W-1:0];
		colb_s1[1] <= col_m[BANK_W-1:0];
		colb_s1[2] <= col_r[BANK_W-1:0];
	end

	always_comb begin
		chain[0].valid = v_s1;
		chain[0].last  = last_s1;
		chain[0].acc   = '0;
		for (int ky = 0; ky < KERNEL_SIZE; ky++) begin
			for (int kx = 0; kx < KERNEL_SIZE; kx++) begin
				chain[0].pix[ky*KERNEL_SIZE + kx] = rd_data[slot_s1[ky]][colb_s1[kx]];
			end
		end
	end

	// ---------------- multiply-accumulate chain ----------------
	for (genvar k = 0; k < TAPS; k++) begin : g_tap
		localparam int KY = k / KERNEL_SIZE;
		localparam int KX = k % KERNEL_SIZE;

		assign loads[k].en   = cfg_wr && (cfg_index == row_reg(KY));
		assign loads[k].coef = cfg_data[COEF_W*KX +: COEF_W];

		cmoc_cell #(
			.TAP        (k),
			.COEF_RESET (coef_reset(k))
		) u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.load    (loads[k]),
			.bus_in  (chain[k]),
			.bus_out (chain[k+1])
		);
	end

	// ---------------- offset, floor and clamp ----------------
	assign sum = chain[TAPS].acc + ACC_W'(ROUND_OFFSET);

	always_comb begin
		if (sum[ACC_W-1]) begin
			pix_clamped = '0;
		end else if (|sum[ACC_W-2:2*PIX_W]) begin
			pix_clamped = PIX_W'(PIX_MAX);
		end else begin
			pix_clamped = sum[2*PIX_W-1:PIX_W];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fin_v_s11 <= 1'b0;
		end else begin
			fin_v_s11 <= chain[TAPS].valid;
		end
	end

	always_ff @(posedge clk) begin
		fin_s11.pixel_out  <= pix_clamped;
		fin_s11.frame_last <= chain[TAPS].last;
	end

	cmoc_fifo #(
		.DEPTH(FIFO_DEPTH)
	) u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.reserve   (emit),
		.push      (fin_v_s11),
		.push_word (fin_s11),
		.valid     (result_valid),
		.stall     (result_stall),
		.word      (result),
		.full      (credit_full)
	);

	assign feed_stall = credit_full;

	`CMOC_NEXT(a_emit_fetch, emit, v_s1, "emitted result missing from fetch stage")
	`CMOC_NEXT(a_frame_wrap, emit && frame_end, out_row_q == '0 && out_col_q == '0, "frame end did not wrap the result position")
	`CMOC_IMPL(a_ahead_src, $rose(ahead_q), $past(is_pix), "frame ahead set without a pixel word")

endmodule

// File: src/cmoc_ram.sv
// generic single write port ram with registered read, new data on collision
module cmoc_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= (we && waddr == raddr) ? wdata : mem[raddr];
	end

endmodule

// File: src/cmoc_cell.sv
// one tap of the kernel: holds its coefficient, adds its product to the passing sum
module cmoc_cell #(
	parameter int TAP = 0,
	parameter logic [cmoc_pkg::COEF_W-1:0] COEF_RESET = '0
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  cmoc_pkg::coef_load_t   load,
	input  cmoc_pkg::cell_bus_t    bus_in,
	output cmoc_pkg::cell_bus_t    bus_out
);
	import cmoc_pkg::*;

	localparam int PROD_W = COEF_W + PIX_W + 1;

	logic [COEF_W-1:0]        coef_q;
	logic signed [PROD_W-1:0] prod;
	logic                     valid_s1;
	cell_bus_t                data_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			coef_q <= COEF_RESET;
		end else if (load.en) begin
			coef_q <= load.coef;
		end
	end

	// pixel is unsigned, so give it a zero sign bit
	assign prod = $signed(coef_q) * $signed({1'b0, bus_in.pix[TAP]});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= bus_in.valid;
		end
	end

	always_ff @(posedge clk) begin
		data_s1.valid <= bus_in.valid;
		data_s1.last  <= bus_in.last;
		data_s1.pix   <= bus_in.pix;
		data_s1.acc   <= bus_in.acc + ACC_W'(prod);
	end

	always_comb begin
		bus_out       = data_s1;
		bus_out.valid = valid_s1;
	end

endmodule

// File: src/cmoc_fifo.sv
// result queue with credit count covering words still in the pipeline
`include "conv3x3_mirror_offset_clamp_top_defines.svh"
module cmoc_fifo #(
	parameter int DEPTH = cmoc_pkg::FIFO_DEPTH
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              reserve,
	input  logic              push,
	input  cmoc_pkg::result_t push_word,
	output logic              valid,
	input  logic              stall,
	output cmoc_pkg::result_t word,
	output logic              full
);
	import cmoc_pkg::*;

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	result_t         q_mem [DEPTH];
	logic [PW-1:0]   wr_q;
	logic [PW-1:0]   rd_q;
	logic [CW-1:0]   cnt_q;
	logic [CW-1:0]   occ_q;
	logic            pop;

	assign pop   = valid & ~stall;
	assign valid = (cnt_q != '0);
	assign word  = q_mem[rd_q];
	assign full  = (occ_q == CW'(DEPTH));

	always_ff @(posedge clk) begin
		if (push) begin
			q_mem[wr_q] <= push_word;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
			occ_q <= '0;
		end else begin
			if (push) begin
				wr_q <= (wr_q == PW'(DEPTH - 1)) ? '0 : wr_q + PW'(1);
			end
			if (pop) begin
				rd_q <= (rd_q == PW'(DEPTH - 1)) ? '0 : rd_q + PW'(1);
			end
			cnt_q <= cnt_q + CW'(push) - CW'(pop);
			// occupancy counts from acceptance, so the queue can never overflow
			occ_q <= occ_q + CW'(reserve) - CW'(pop);
		end
	end

	`CMOC_IMPL(a_push_room, push, cnt_q != CW'(DEPTH), "result pushed into a full queue")
	`CMOC_CHECK(a_credit_cover, occ_q >= cnt_q, "credit count below queue fill")
	`CMOC_IMPL(a_no_overbook, full, !reserve, "result reserved with no credit left")

endmodule
